// ----- src/rrtq_pkg.sv -----
// Package with the payload types, status codes and field widths of the round robin queue.
`default_nettype none

package rrtq_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned ID_W     = 16;
  localparam int unsigned UNITS_W  = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned WAIT_W   = 5;
  localparam int unsigned CAP_W    = 5;

  // Capacity after reset.
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd10;

  // Request codes.
  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_SERVE   = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ROTATED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REMOVED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd4;

  // One incoming request.
  typedef struct packed {
    logic               opcode;
    logic [ID_W-1:0]    requester_id;
    logic [UNITS_W-1:0] work_units;
  } rrtq_in_t;

  // One result.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     served_id;
    logic [UNITS_W-1:0]  units_left;
    logic [WAIT_W-1:0]   waiting;
  } rrtq_out_t;

  // Contents of one queue cell.
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [UNITS_W-1:0] units;
  } rrtq_entry_t;

  // Per-cell control: shift toward the head, or load the new entry.
  typedef struct packed {
    logic shift;
    logic load;
  } rrtq_cell_ctl_t;

endpackage

`default_nettype wire

// ----- src/rrtq_cell.sv -----
// One cell of the queue chain: holds an entry and takes its upper neighbor on a shift.
`default_nettype none

module rrtq_cell (
  input  wire                     clk,
  input  rrtq_pkg::rrtq_cell_ctl_t ctl,
  input  rrtq_pkg::rrtq_entry_t    upper,
  input  rrtq_pkg::rrtq_entry_t    load_data,
  output rrtq_pkg::rrtq_entry_t    data
);
  import rrtq_pkg::*;

  // A load wins over a shift, so a rotated entry lands in the freed tail cell.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      data <= load_data;
    end else if (ctl.shift) begin
      data <= upper;
    end
  end

endmodule

`default_nettype wire

// ----- src/round_robin_ticket_queue.sv -----
// Top level of the round robin ticket queue: control, the cell chain and the result register.
`default_nettype none

// Round robin queue of requesters kept in a chain of MAX_SLOTS cells, the head in the
// first cell. An enqueue loads the cell just past the last occupied one, and a serve
// shifts the whole chain one cell toward the head and, in the same cycle, reloads the tail
// cell with the decremented head entry when it rotates. The result is registered when the
// request is accepted, and a new request is accepted in every cycle in which the output
// register is free or being taken. The capacity register limits how many requesters may
// wait; zero acts as one and values above MAX_SLOTS act as MAX_SLOTS. The user must write
// it only while no request is in flight; the block itself does not enforce this.
module round_robin_ticket_queue #(
  parameter int unsigned MAX_SLOTS = 16
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_stall,
  input  rrtq_pkg::rrtq_in_t  in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output rrtq_pkg::rrtq_out_t out_data,
  input  wire                 cfg_wen,
  input  wire [4:0]           cfg_wdata
);
  import rrtq_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic [CAP_W-1:0] capacity;
  logic [CNT_W-1:0] occupancy;
  logic [CNT_W-1:0] occupancy_next;

  logic accept;
  logic full;
  logic empty;
  logic removed;
  logic do_shift;
  logic do_load;
  logic [CNT_W-1:0] load_pos;
  logic [CMP_W-1:0] cap_eff;
  logic [UNITS_W-1:0] head_dec;

  rrtq_entry_t    chain [MAX_SLOTS];
  rrtq_cell_ctl_t cell_ctl [MAX_SLOTS];
  rrtq_entry_t    load_data;
  rrtq_out_t      result;

  // The request side waits only while a finished result is held.
  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  // Capacity register.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_wen) begin
      capacity <= cfg_wdata;
    end
  end

  // Effective capacity is clamped to the range one to MAX_SLOTS.
  always_comb begin
    cap_eff = CMP_W'(capacity);
    if (cap_eff == '0) begin
      cap_eff = CMP_W'(1);
    end
    if (cap_eff > CMP_W'(MAX_SLOTS)) begin
      cap_eff = CMP_W'(MAX_SLOTS);
    end
  end

  assign full     = CMP_W'(occupancy) >= cap_eff;
  assign empty    = occupancy == '0;
  assign head_dec = (chain[0].units != '0) ? chain[0].units - UNITS_W'(1) : '0;
  assign removed  = head_dec == '0;

  // Decide the chain operation and the result of this request.
  always_comb begin
    do_shift       = 1'b0;
    do_load        = 1'b0;
    load_pos       = occupancy;
    load_data      = chain[0];
    occupancy_next = occupancy;
    result         = '0;
    if (in_data.opcode == OP_ENQUEUE) begin
      load_data.id    = in_data.requester_id;
      load_data.units = in_data.work_units;
      if (full) begin
        result.status = ST_FULL;
      end else begin
        do_load           = accept;
        occupancy_next    = occupancy + CNT_W'(1);
        result.status     = ST_ADDED;
        result.served_id  = in_data.requester_id;
        result.units_left = in_data.work_units;
      end
    end else if (empty) begin
      result.status = ST_EMPTY;
    end else begin
      do_shift         = accept;
      load_data.units  = head_dec;
      load_pos         = occupancy - CNT_W'(1);
      result.served_id = chain[0].id;
      if (removed) begin
        occupancy_next = occupancy - CNT_W'(1);
        result.status  = ST_REMOVED;
      end else begin
        do_load           = accept;
        result.status     = ST_ROTATED;
        result.units_left = head_dec;
      end
    end
    result.waiting = WAIT_W'(occupancy_next);
  end

  // Occupancy count.
  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
    end else if (accept) begin
      occupancy <= occupancy_next;
    end
  end

  // Chain of cells, the head in cell zero.
  for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_cell
    assign cell_ctl[i].shift = do_shift;
    assign cell_ctl[i].load  = do_load && (load_pos == CNT_W'(i));

    if (i == MAX_SLOTS - 1) begin : g_last
      rrtq_cell u_cell (
        .clk       (clk),
        .ctl       (cell_ctl[i]),
        .upper     (chain[i]),
        .load_data (load_data),
        .data      (chain[i])
      );
    end else begin : g_mid
      rrtq_cell u_cell (
        .clk       (clk),
        .ctl       (cell_ctl[i]),
        .upper     (chain[i+1]),
        .load_data (load_data),
        .data      (chain[i])
      );
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

  // The count never exceeds the number of cells.
  assert property (@(posedge clk) disable iff (rst)
    CNT_W'(MAX_SLOTS) >= occupancy)
    else $error("occupancy above number of cells");

  // The count moves only with an accepted request.
  assert property (@(posedge clk) disable iff (rst)
    !accept |=> occupancy == $past(occupancy))
    else $error("occupancy changed without a request");

  // An enqueue into a full queue leaves the count alone and reports full.
  assert property (@(posedge clk) disable iff (rst)
    accept && in_data.opcode == OP_ENQUEUE && full |=>
      occupancy == $past(occupancy) && out_valid && out_data.status == ST_FULL)
    else $error("enqueue on full queue mishandled");

  // A serve of an empty queue reports empty with zero waiting.
  assert property (@(posedge clk) disable iff (rst)
    accept && in_data.opcode == OP_SERVE && empty |=>
      out_valid && out_data.status == ST_EMPTY && out_data.waiting == '0)
    else $error("serve on empty queue mishandled");

endmodule

`default_nettype wire

// ----- verif/tb_round_robin_ticket_queue.sv -----
// Self-checking testbench for the round robin ticket queue, driven by a directed table and random phases.
`default_nettype none

module tb_round_robin_ticket_queue;
  import rrtq_pkg::*;

  localparam int unsigned SLOTS        = 16;
  localparam int unsigned NUM_PHASES   = 16;
  localparam int unsigned PHASE_ITEMS  = 100;
  localparam int unsigned QUIET_PHASES = 3;
  localparam int unsigned CALM_PHASE   = 6;
  localparam int unsigned HOLD_PHASE   = 4;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned PRINT_LIMIT  = 50;

  // Kinds of rows in the directed table.
  localparam logic [1:0] ROW_CONFIG  = 2'd0;
  localparam logic [1:0] ROW_PREDICT = 2'd1;
  localparam logic [1:0] ROW_TYPED   = 2'd2;

  typedef struct packed {
    logic [1:0]       kind;
    logic [CAP_W-1:0] cap_value;
    rrtq_in_t         req;
    rrtq_out_t        res;
  } dir_row_t;

  // Directed opening: empty serve, field extremes, zero units, capacity extremes,
  // rotation of a full queue and capacity lowered below the number waiting.
  localparam dir_row_t DIRECTED [0:22] = '{
    {ROW_TYPED,   5'd0,  OP_SERVE,   16'hFFFF, 8'hFF, ST_EMPTY,   16'h0000, 8'h00, 5'd0},
    {ROW_TYPED,   5'd0,  OP_ENQUEUE, 16'hFFFF, 8'hFF, ST_ADDED,   16'hFFFF, 8'hFF, 5'd1},
    {ROW_TYPED,   5'd0,  OP_ENQUEUE, 16'h0000, 8'h00, ST_ADDED,   16'h0000, 8'h00, 5'd2},
    {ROW_TYPED,   5'd0,  OP_ENQUEUE, 16'h1234, 8'h01, ST_ADDED,   16'h1234, 8'h01, 5'd3},
    {ROW_TYPED,   5'd0,  OP_SERVE,   16'h0000, 8'h00, ST_ROTATED, 16'hFFFF, 8'hFE, 5'd3},
    {ROW_TYPED,   5'd0,  OP_SERVE,   16'h0000, 8'h00, ST_REMOVED, 16'h0000, 8'h00, 5'd2},
    {ROW_TYPED,   5'd0,  OP_SERVE,   16'h0000, 8'h00, ST_REMOVED, 16'h1234, 8'h00, 5'd1},
    {ROW_CONFIG,  5'd0,  OP_ENQUEUE, 16'h0000, 8'h00, ST_ADDED,   16'h0000, 8'h00, 5'd0},
    {ROW_TYPED,   5'd0,  OP_ENQUEUE, 16'h5555, 8'hAA, ST_FULL,    16'h0000, 8'h00, 5'd1},
    {ROW_TYPED,   5'd0,  OP_SERVE,   16'h0000, 8'h00, ST_ROTATED, 16'hFFFF, 8'hFD, 5'd1},
    {ROW_CONFIG,  5'd31, OP_ENQUEUE, 16'h0000, 8'h00, ST_ADDED,   16'h0000, 8'h00, 5'd0},
    {ROW_PREDICT, 5'd0,  OP_ENQUEUE, 16'hAAAA, 8'h80, ST_ADDED,   16'h0000, 8'h00, 5'd0},
    {ROW_PREDICT, 5'd0,  OP_ENQUEUE, 16'h00FF, 8'h7F, ST_ADDED,   16'h0000, 8'h00, 5'd0},
    {ROW_PREDICT, 5'd0,  OP_ENQUEUE, 16'hFF00, 8'h02, ST_ADDED,   16'h0000, 8'h00, 5'd0},
    {ROW_CONFIG,  5'd2,  OP_ENQUEUE, 16'h0000, 8'h00, ST_ADDED,   16'h0000, 8'h00, 5'd0},
    {ROW_TYPED,   5'd0,  OP_ENQUEUE, 16'h0F0F, 8'h55, ST_FULL,    16'h0000, 8'h00, 5'd4},
    {ROW_TYPED,   5'd0,  OP_SERVE,   16'h0000, 8'h00, ST_ROTATED, 16'hFFFF, 8'hFC, 5'd4},
    {ROW_PREDICT, 5'd0,  OP_SERVE,   16'h0000, 8'h00, ST_ADDED,   16'h0000, 8'h00, 5'd0},
    {ROW_PREDICT, 5'd0,  OP_SERVE,   16'h0000, 8'h00, ST_ADDED,   16'h0000, 8'h00, 5'd0},
    {ROW_PREDICT, 5'd0,  OP_SERVE,   16'h0000, 8'h00, ST_ADDED,   16'h0000, 8'h00, 5'd0},
    {ROW_CONFIG,  5'd16, OP_ENQUEUE, 16'h0000, 8'h00, ST_ADDED,   16'h0000, 8'h00, 5'd0},
    {ROW_PREDICT, 5'd0,  OP_SERVE,   16'hFFFF, 8'hFF, ST_ADDED,   16'h0000, 8'h00, 5'd0},
    {ROW_PREDICT, 5'd0,  OP_SERVE,   16'h0000, 8'h00, ST_ADDED,   16'h0000, 8'h00, 5'd0}
  };

  logic             clk;
  logic             rst       = 1'b1;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  rrtq_in_t         in_data   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  rrtq_out_t        out_data;
  logic             cfg_wen   = 1'b0;
  logic [CAP_W-1:0] cfg_wdata = '0;

  // Predicted queue contents and capacity, plus results still to arrive.
  rrtq_entry_t      waiting_line [$];
  logic [CAP_W-1:0] model_capacity = CAP_RESET;
  rrtq_out_t        pending_results [$];

  int unsigned mismatches   = 0;
  int unsigned cycle_count  = 0;
  logic        quiet        = 1'b0;
  logic        hold_request = 1'b0;

  round_robin_ticket_queue #(.MAX_SLOTS(SLOTS)) u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
  end

  // Ends a run that stops making progress.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) begin
      $display("mismatch %0d at cycle %0d: %s got 0x%0h, expected 0x%0h",
               mismatches, cycle_count, what, got, want);
    end
  endtask

  // Advances the predicted queue by one request and returns its result.
  function automatic rrtq_out_t predict_outcome(input rrtq_in_t req);
    rrtq_out_t   res;
    rrtq_entry_t head;
    int unsigned limit;
    res = '0;
    limit = (model_capacity == 0) ? 1 : ((model_capacity > SLOTS) ? SLOTS : model_capacity);
    if (req.opcode == OP_ENQUEUE) begin
      if (waiting_line.size() >= limit) begin
        res.status = ST_FULL;
      end else begin
        waiting_line.push_back({req.requester_id, req.work_units});
        res.status = ST_ADDED;
        res.served_id = req.requester_id;
        res.units_left = req.work_units;
      end
    end else if (waiting_line.size() == 0) begin
      res.status = ST_EMPTY;
    end else begin
      head = waiting_line.pop_front();
      res.served_id = head.id;
      if (head.units != 0) head.units = head.units - 1'b1;
      if (head.units == 0) begin
        res.status = ST_REMOVED;
      end else begin
        waiting_line.push_back(head);
        res.status = ST_ROTATED;
        res.units_left = head.units;
      end
    end
    res.waiting = WAIT_W'(waiting_line.size());
    return res;
  endfunction

  // Offers one request, after an optional idle burst, and records its result once accepted.
  task automatic send_request(input rrtq_in_t req, input logic typed, input rrtq_out_t typed_res);
    int unsigned gap;
    rrtq_out_t   predicted;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = req;
    do @(posedge clk); while (in_stall);
    predicted = predict_outcome(req);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  // Writes the capacity once every result is out and the block is idle.
  task automatic write_capacity(input logic [CAP_W-1:0] value);
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    @(negedge clk);
    cfg_wen = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_wen = 1'b0;
    model_capacity = value;
  endtask

  // Request side: directed table first, then random phases.
  initial begin
    int unsigned      r;
    int unsigned      phase;
    int unsigned      n;
    int unsigned      enq_pct;
    logic [CAP_W-1:0] cap;
    rrtq_in_t         req;
    wait (rst == 1'b0);
    for (r = 0; r < $size(DIRECTED); r++) begin
      if (DIRECTED[r].kind == ROW_CONFIG) begin
        write_capacity(DIRECTED[r].cap_value);
      end else begin
        send_request(DIRECTED[r].req, DIRECTED[r].kind == ROW_TYPED, DIRECTED[r].res);
      end
    end

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin
          cap = 5'd16;
        end
        1: begin
          cap = 5'd31;
        end
        2: begin
          cap = 5'd1;
        end
        3: begin
          cap = 5'd0;
        end
        default: begin
          cap = CAP_W'($urandom_range(0, 31));
        end
      endcase
      write_capacity(cap);
      quiet = (phase >= NUM_PHASES - QUIET_PHASES) || (phase == CALM_PHASE);
      if (phase == HOLD_PHASE) hold_request = 1'b1;
      enq_pct = (phase < 2) ? 75 : $urandom_range(30, 75);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        req.opcode = ($urandom_range(0, 99) < enq_pct) ? OP_ENQUEUE : OP_SERVE;
        req.requester_id = ID_W'($urandom_range(0, 65535));
        // Mostly short jobs so that entries rotate out; a few long ones stay around.
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            req.work_units = UNITS_W'($urandom_range(0, 4));
          end
          6, 7, 8: begin
            req.work_units = UNITS_W'($urandom_range(5, 20));
          end
          default: begin
            req.work_units = UNITS_W'($urandom_range(0, 255));
          end
        endcase
        send_request(req, 1'b0, '0);
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Result side: random stall bursts, one long hold, and none while quiet.
  initial begin
    int unsigned stall_left;
    int unsigned held;
    logic        hold_done;
    stall_left = 0;
    hold_done = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        out_stall = 1'b1;
        for (held = 1; held < LONG_HOLD; held++) @(negedge clk);
        stall_left = 0;
      end else if (quiet) begin
        out_stall = 1'b0;
        stall_left = 0;
      end else if (stall_left > 0) begin
        stall_left--;
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall = 1'b1;
        stall_left = $urandom_range(1, 9) - 1;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // Compares each accepted result with the oldest prediction.
  always @(posedge clk) begin
    rrtq_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, status", out_data.status, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status) begin
          report_mismatch("status", out_data.status, want.status);
        end
        if (out_data.served_id !== want.served_id) begin
          report_mismatch("served_id", out_data.served_id, want.served_id);
        end
        if (out_data.units_left !== want.units_left) begin
          report_mismatch("units_left", out_data.units_left, want.units_left);
        end
        if (out_data.waiting !== want.waiting) begin
          report_mismatch("waiting", out_data.waiting, want.waiting);
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- files.f -----
src/rrtq_pkg.sv
src/rrtq_cell.sv
src/round_robin_ticket_queue.sv
verif/tb_round_robin_ticket_queue.sv
